// ===== sv/per_key_block_history_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-key block history table
// Shared concurrent assertion forms: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef PER_KEY_BLOCK_HISTORY_TABLE_UNIT_MACROS_SVH
`define PER_KEY_BLOCK_HISTORY_TABLE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PKBHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PKBHT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pkbht_pkg.sv =====
// ----------------------------------------------------------------------------
// pkbht_pkg
// Sizes, field layout, codes and helpers of the per-key block history table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pkbht_pkg;

    // Table sizing
    localparam int KEY_COUNT     = 1024;
    localparam int HISTORY_DEPTH = 8;
    localparam int MAX_HITS      = 255;
    localparam int TAG_BITS      = 64;

    localparam int KEY_W   = $clog2(KEY_COUNT);
    localparam int POS_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int CNT_W   = $clog2(MAX_HITS + 1);
    localparam int SLOT_N  = KEY_COUNT * HISTORY_DEPTH;
    localparam int SLOT_AW = $clog2(SLOT_N);

    // Fixed port field widths
    localparam int KEY_IN_W   = 10;
    localparam int TAG_IN_W   = 64;
    localparam int POS_IN_W   = 3;
    localparam int CNT_OUT_W  = 8;
    localparam int FILL_OUT_W = 4;

    // Slave tdata layout: key_index, block_tag, entry_position
    localparam int IN_KEY_LSB  = 0;
    localparam int IN_TAG_LSB  = IN_KEY_LSB + KEY_IN_W;
    localparam int IN_POS_LSB  = IN_TAG_LSB + TAG_IN_W;
    localparam int IN_BITS     = IN_POS_LSB + POS_IN_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    // Slave tuser layout: opcode, backward_mode
    localparam int IN_OP_W     = 2;
    localparam int IN_BWD_BIT  = IN_OP_W;
    localparam int IN_USER_W   = IN_OP_W + 1;

    // Master tdata layout
    localparam int OUT_KNOWN_BIT   = 0;
    localparam int OUT_CHANGED_BIT = 1;
    localparam int OUT_VALID_BIT   = 2;
    localparam int OUT_TAG_LSB     = 3;
    localparam int OUT_CNT_LSB     = OUT_TAG_LSB + TAG_IN_W;
    localparam int OUT_FILL_LSB    = OUT_CNT_LSB + CNT_OUT_W;
    localparam int OUT_BITS        = OUT_FILL_LSB + FILL_OUT_W;
    localparam int OUT_DATA_W      = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_RECORD   = 2'd1,
        OP_READ     = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_SLOT,
        ST_OUT
    } t_state;

    // Per-key ring head word
    typedef struct packed {
        logic              present;
        logic [POS_W-1:0]  start;
        logic [FILL_W-1:0] fill;
    } t_key_word;

    // One history slot
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [CNT_W-1:0]    cnt;
    } t_slot_word;

    localparam int KEY_WORD_W  = $bits(t_key_word);
    localparam int SLOT_WORD_W = $bits(t_slot_word);

    // Flat slot address of a ring position of a key
    function automatic logic [SLOT_AW-1:0] f_slot_addr(input logic [KEY_W-1:0] key,
                                                      input logic [POS_W-1:0] ring);
        f_slot_addr = SLOT_AW'(32'(key) * HISTORY_DEPTH + 32'(ring));
    endfunction

endpackage

// ===== sv/pkbht_ram.sv =====
// ----------------------------------------------------------------------------
// pkbht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkbht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pkbht_ring_alu.sv =====
// ----------------------------------------------------------------------------
// pkbht_ring_alu
// Shared ring index unit: (start + offset) modulo the history depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkbht_ring_alu (
    input  logic [pkbht_pkg::POS_W-1:0]  i_start,
    input  logic [pkbht_pkg::FILL_W-1:0] i_ofs,
    output logic [pkbht_pkg::POS_W-1:0]  o_ring
);

    localparam int SUM_W = pkbht_pkg::FILL_W + 1;

    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_wrap;

    // Add, then fold once: correct while both operands stay below the depth
    always_comb begin
        w_sum  = SUM_W'(i_start) + SUM_W'(i_ofs);
        w_wrap = w_sum - SUM_W'(pkbht_pkg::HISTORY_DEPTH);
        if (w_sum >= SUM_W'(pkbht_pkg::HISTORY_DEPTH)) begin
            o_ring = pkbht_pkg::POS_W'(w_wrap);
        end else begin
            o_ring = pkbht_pkg::POS_W'(w_sum);
        end
    end

endmodule

// ===== sv/per_key_block_history_table_unit.sv =====
// ----------------------------------------------------------------------------
// per_key_block_history_table_unit
// Per-key rings of recent block tags with saturating hit counts.
//
// Usage:
//   Commands enter on the s_axis channel: tuser carries opcode and
//   backward_mode, tdata carries key_index, block_tag and entry_position.
//   Every command returns exactly one beat on m_axis (key_known,
//   history_changed, entry_valid, entry_tag, entry_count, history_fill).
//   The block works on one command at a time under a small sequencer:
//   accept, key head read, then slot read and update through the shared
//   ring index unit. Register, ignored and unknown-key commands go from
//   the key head step straight to the result beat; record and read on a
//   known key pass through the slot step first. A new beat can be taken
//   from the cycle after the result is taken, so commands never overlap.
//   After reset the key head RAM is swept to zero, one key per cycle,
//   over all KEY_COUNT (1024) keys; s_axis_tready stays low meanwhile.
//   While m_axis_tready is low the result beat holds and no new command
//   is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_key_block_history_table_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: key_index[9:0], block_tag[73:10], entry_position[76:74], zero pad
    input  logic [pkbht_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0], backward_mode[2]
    input  logic [pkbht_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: key_known[0], history_changed[1], entry_valid[2], entry_tag[66:3],
    //        entry_count[74:67], history_fill[78:75], zero pad
    output logic [pkbht_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int KEY_W   = pkbht_pkg::KEY_W;
    localparam int POS_W   = pkbht_pkg::POS_W;
    localparam int FILL_W  = pkbht_pkg::FILL_W;
    localparam int CNT_W   = pkbht_pkg::CNT_W;
    localparam int TAG_W   = pkbht_pkg::TAG_BITS;
    localparam int SLOT_AW = pkbht_pkg::SLOT_AW;
    localparam int PAD_W   = pkbht_pkg::OUT_DATA_W - pkbht_pkg::OUT_BITS;

    // Control state
    pkbht_pkg::t_state r_state, n_state;
    logic [KEY_W-1:0]  r_clr_cnt, n_clr_cnt;

    // Captured command
    pkbht_pkg::t_op                  r_op, n_op;
    logic                            r_bwd, n_bwd;
    logic                            r_in_range, n_in_range;
    logic [KEY_W-1:0]                r_key, n_key;
    logic [TAG_W-1:0]                r_tag, n_tag;
    logic [pkbht_pkg::POS_IN_W-1:0]  r_pos, n_pos;

    // Key head and slot address held between steps
    logic [POS_W-1:0]   r_start, n_start;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [SLOT_AW-1:0] r_slot_addr, n_slot_addr;

    // Result register
    logic                              r_o_known, n_o_known;
    logic                              r_o_changed, n_o_changed;
    logic                              r_o_valid, n_o_valid;
    logic [pkbht_pkg::TAG_IN_W-1:0]    r_o_tag, n_o_tag;
    logic [pkbht_pkg::CNT_OUT_W-1:0]   r_o_cnt, n_o_cnt;
    logic [pkbht_pkg::FILL_OUT_W-1:0]  r_o_fill, n_o_fill;

    // RAM ports
    logic                             w_key_we;
    logic [KEY_W-1:0]                 w_key_waddr, w_key_raddr;
    pkbht_pkg::t_key_word             w_key_wdata, w_key_rd;
    logic [pkbht_pkg::KEY_WORD_W-1:0] w_key_rdata;
    logic                             w_slot_we;
    logic [SLOT_AW-1:0]               w_slot_waddr, w_slot_raddr;
    pkbht_pkg::t_slot_word            w_slot_wdata, w_slot_rd;
    logic [pkbht_pkg::SLOT_WORD_W-1:0] w_slot_rdata;

    // Shared ring index unit
    logic [POS_W-1:0]  w_alu_start;
    logic [FILL_W-1:0] w_alu_ofs;
    logic [POS_W-1:0]  w_alu_ring;

    // Step decode helpers
    logic w_known;
    logic w_match;
    logic w_full;

    pkbht_ram #(
        .WIDTH (pkbht_pkg::KEY_WORD_W),
        .DEPTH (pkbht_pkg::KEY_COUNT)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_key_waddr),
        .i_wdata (w_key_wdata),
        .i_raddr (w_key_raddr),
        .o_rdata (w_key_rdata)
    );

    pkbht_ram #(
        .WIDTH (pkbht_pkg::SLOT_WORD_W),
        .DEPTH (pkbht_pkg::SLOT_N)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    pkbht_ring_alu u_ring_alu (
        .i_start (w_alu_start),
        .i_ofs   (w_alu_ofs),
        .o_ring  (w_alu_ring)
    );

    assign w_key_rd  = pkbht_pkg::t_key_word'(w_key_rdata);
    assign w_slot_rd = pkbht_pkg::t_slot_word'(w_slot_rdata);

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pkbht_pkg::ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_bwd       <= n_bwd;
        r_in_range  <= n_in_range;
        r_key       <= n_key;
        r_tag       <= n_tag;
        r_pos       <= n_pos;
        r_start     <= n_start;
        r_fill      <= n_fill;
        r_slot_addr <= n_slot_addr;
        r_o_known   <= n_o_known;
        r_o_changed <= n_o_changed;
        r_o_valid   <= n_o_valid;
        r_o_tag     <= n_o_tag;
        r_o_cnt     <= n_o_cnt;
        r_o_fill    <= n_o_fill;
    end

    // Sequencer: next state, RAM controls, ring unit operands, result
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_op        = r_op;
        n_bwd       = r_bwd;
        n_in_range  = r_in_range;
        n_key       = r_key;
        n_tag       = r_tag;
        n_pos       = r_pos;
        n_start     = r_start;
        n_fill      = r_fill;
        n_slot_addr = r_slot_addr;
        n_o_known   = r_o_known;
        n_o_changed = r_o_changed;
        n_o_valid   = r_o_valid;
        n_o_tag     = r_o_tag;
        n_o_cnt     = r_o_cnt;
        n_o_fill    = r_o_fill;

        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        w_key_we     = 1'b0;
        w_key_waddr  = r_key;
        w_key_wdata  = '0;
        w_key_raddr  = r_key;
        w_slot_we    = 1'b0;
        w_slot_waddr = r_slot_addr;
        w_slot_wdata = '0;
        w_slot_raddr = r_slot_addr;

        w_alu_start = r_start;
        w_alu_ofs   = '0;

        w_known = r_in_range && w_key_rd.present;
        w_match = (r_fill != '0) && (w_slot_rd.tag == r_tag);
        w_full  = (r_fill == FILL_W'(pkbht_pkg::HISTORY_DEPTH));

        case (r_state)
            // Sweep key heads to zero after reset
            pkbht_pkg::ST_CLEAR: begin
                w_key_we    = 1'b1;
                w_key_waddr = r_clr_cnt;
                n_clr_cnt   = r_clr_cnt + 1'b1;
                if (r_clr_cnt == KEY_W'(pkbht_pkg::KEY_COUNT - 1)) begin
                    n_state = pkbht_pkg::ST_IDLE;
                end
            end

            // Take a command beat and start the key head read
            pkbht_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_key_raddr   = KEY_W'(s_axis_tdata[pkbht_pkg::IN_KEY_LSB +:
                                                    pkbht_pkg::KEY_IN_W]);
                if (s_axis_tvalid) begin
                    n_op       = pkbht_pkg::t_op'(s_axis_tuser[pkbht_pkg::IN_OP_W-1:0]);
                    n_bwd      = s_axis_tuser[pkbht_pkg::IN_BWD_BIT];
                    n_key      = w_key_raddr;
                    n_in_range = 32'(s_axis_tdata[pkbht_pkg::IN_KEY_LSB +:
                                                  pkbht_pkg::KEY_IN_W])
                                 < pkbht_pkg::KEY_COUNT;
                    n_tag      = s_axis_tdata[pkbht_pkg::IN_TAG_LSB +: TAG_W];
                    n_pos      = s_axis_tdata[pkbht_pkg::IN_POS_LSB +:
                                              pkbht_pkg::POS_IN_W];
                    n_state    = pkbht_pkg::ST_KEY;
                end
            end

            // Key head is here: register a key, or locate the slot to read
            pkbht_pkg::ST_KEY: begin
                n_start     = w_key_rd.start;
                n_fill      = w_key_rd.fill;
                w_alu_start = w_key_rd.start;
                if (r_op == pkbht_pkg::OP_READ) begin
                    w_alu_ofs = FILL_W'(r_pos);
                end else if (r_bwd) begin
                    w_alu_ofs = '0;
                end else begin
                    w_alu_ofs = w_key_rd.fill - 1'b1;
                end
                w_slot_raddr = pkbht_pkg::f_slot_addr(r_key, w_alu_ring);
                n_slot_addr  = w_slot_raddr;

                n_o_known   = w_known;
                n_o_changed = 1'b0;
                n_o_valid   = 1'b0;
                n_o_tag     = '0;
                n_o_cnt     = '0;
                n_o_fill    = w_known ? pkbht_pkg::FILL_OUT_W'(w_key_rd.fill) : '0;
                n_state     = pkbht_pkg::ST_OUT;

                case (r_op)
                    pkbht_pkg::OP_REGISTER: begin
                        n_o_known = r_in_range;
                        if (r_in_range) begin
                            w_key_we            = 1'b1;
                            w_key_wdata.present = 1'b1;
                            w_key_wdata.start   = w_key_rd.start;
                            w_key_wdata.fill    = w_key_rd.fill;
                        end
                    end
                    pkbht_pkg::OP_RECORD,
                    pkbht_pkg::OP_READ: begin
                        if (w_known) begin
                            n_state = pkbht_pkg::ST_SLOT;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Slot is here: read it out, or bump or push
            pkbht_pkg::ST_SLOT: begin
                n_o_known = 1'b1;
                n_o_fill  = pkbht_pkg::FILL_OUT_W'(r_fill);
                n_state   = pkbht_pkg::ST_OUT;
                w_key_wdata.present = 1'b1;
                w_key_wdata.start   = r_start;
                w_key_wdata.fill    = r_fill;

                if (r_op == pkbht_pkg::OP_READ) begin
                    if (r_pos < r_fill) begin
                        n_o_valid = 1'b1;
                        n_o_tag   = pkbht_pkg::TAG_IN_W'(w_slot_rd.tag);
                        n_o_cnt   = pkbht_pkg::CNT_OUT_W'(w_slot_rd.cnt);
                    end
                end else if (w_match) begin
                    // Raise the count of the matching end entry
                    if (w_slot_rd.cnt < CNT_W'(pkbht_pkg::MAX_HITS)) begin
                        w_slot_we        = 1'b1;
                        w_slot_wdata.tag = w_slot_rd.tag;
                        w_slot_wdata.cnt = w_slot_rd.cnt + 1'b1;
                        n_o_changed      = 1'b1;
                    end
                end else if (r_bwd) begin
                    // Push at the front unless full
                    if (!w_full) begin
                        w_alu_ofs         = FILL_W'(pkbht_pkg::HISTORY_DEPTH - 1);
                        w_key_we          = 1'b1;
                        w_key_wdata.start = w_alu_ring;
                        w_key_wdata.fill  = r_fill + 1'b1;
                        w_slot_we         = 1'b1;
                        w_slot_waddr      = pkbht_pkg::f_slot_addr(r_key, w_alu_ring);
                        w_slot_wdata.tag  = r_tag;
                        w_slot_wdata.cnt  = CNT_W'(1);
                        n_o_changed       = 1'b1;
                        n_o_fill          = pkbht_pkg::FILL_OUT_W'(r_fill + 1'b1);
                    end
                end else begin
                    // Push at the back, dropping the front when full
                    w_key_we         = 1'b1;
                    w_slot_we        = 1'b1;
                    w_slot_wdata.tag = r_tag;
                    w_slot_wdata.cnt = CNT_W'(1);
                    n_o_changed      = 1'b1;
                    if (w_full) begin
                        w_alu_ofs         = FILL_W'(1);
                        w_key_wdata.start = w_alu_ring;
                        w_slot_waddr      = pkbht_pkg::f_slot_addr(r_key, r_start);
                    end else begin
                        w_alu_ofs        = r_fill;
                        w_key_wdata.fill = r_fill + 1'b1;
                        w_slot_waddr     = pkbht_pkg::f_slot_addr(r_key, w_alu_ring);
                        n_o_fill         = pkbht_pkg::FILL_OUT_W'(r_fill + 1'b1);
                    end
                end
            end

            // Hold the result beat until taken
            pkbht_pkg::ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = pkbht_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = pkbht_pkg::ST_IDLE;
            end
        endcase
    end

    // Pack the result beat
    assign m_axis_tdata = {{PAD_W{1'b0}}, r_o_fill, r_o_cnt, r_o_tag,
                           r_o_valid, r_o_changed, r_o_known};

endmodule

// ===== sv/pkbht_checker.sv =====
// ----------------------------------------------------------------------------
// pkbht_checker
// Port-level checks of the history table, bound to the top level.
// ----------------------------------------------------------------------------
`include "per_key_block_history_table_unit_macros.svh"
`timescale 1ns / 1ps

module pkbht_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [pkbht_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [pkbht_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [pkbht_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic w_in_beat;
    logic w_out_flag;
    logic [pkbht_pkg::FILL_OUT_W-1:0] w_out_fill;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == s_axis_tuser)
                        && (s_axis_tdata == s_axis_tdata);
    assign w_out_flag = m_axis_tdata[pkbht_pkg::OUT_CHANGED_BIT]
                        || m_axis_tdata[pkbht_pkg::OUT_VALID_BIT];
    assign w_out_fill = m_axis_tdata[pkbht_pkg::OUT_FILL_LSB +: pkbht_pkg::FILL_OUT_W];

    // Result valid holds while stalled
    `PKBHT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")

    // One command at a time: no result in the cycle after a command beat
    `PKBHT_ASSERT_NXT(a_busy_after_in, i_clk, i_rst_n, w_in_beat, !s_axis_tready && !m_axis_tvalid, "block not busy after command beat")

    // No command taken while a result waits
    `PKBHT_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "command accepted while result pending")

    // Changes and valid entries only on known keys with a non-empty ring
    `PKBHT_ASSERT_NOW(a_flag_known, i_clk, i_rst_n, m_axis_tvalid && w_out_flag, m_axis_tdata[pkbht_pkg::OUT_KNOWN_BIT] && (w_out_fill != '0), "flag on unknown key or empty ring")

    // Fill never exceeds the ring depth
    `PKBHT_ASSERT_NOW(a_fill_range, i_clk, i_rst_n, m_axis_tvalid, 32'(w_out_fill) <= pkbht_pkg::HISTORY_DEPTH, "history fill beyond ring depth")

endmodule

bind per_key_block_history_table_unit pkbht_checker u_pkbht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the per-key block history table. Commands go in on
// s_axis, one result beat per command comes back on m_axis. A software copy
// of every ring predicts each beat, and the beats are checked field by field
// in order. Directed cases cover register, unused opcode, both record modes,
// full rings and saturated counts. Random traffic, mostly on a small key pool,
// runs under three settings of sender and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int EXP_DEPTH      = 16;

    localparam int KEY_COUNT     = pkbht_pkg::KEY_COUNT;
    localparam int HISTORY_DEPTH = pkbht_pkg::HISTORY_DEPTH;
    localparam int MAX_HITS      = pkbht_pkg::MAX_HITS;
    localparam int SLOT_N        = pkbht_pkg::SLOT_N;
    localparam int POS_W         = pkbht_pkg::POS_W;
    localparam int FILL_W        = pkbht_pkg::FILL_W;
    localparam int KEY_IN_W      = pkbht_pkg::KEY_IN_W;
    localparam int TAG_IN_W      = pkbht_pkg::TAG_IN_W;
    localparam int POS_IN_W      = pkbht_pkg::POS_IN_W;
    localparam int CNT_OUT_W     = pkbht_pkg::CNT_OUT_W;
    localparam int FILL_OUT_W    = pkbht_pkg::FILL_OUT_W;
    localparam int IN_DATA_W     = pkbht_pkg::IN_DATA_W;
    localparam int IN_USER_W     = pkbht_pkg::IN_USER_W;
    localparam int OUT_DATA_W    = pkbht_pkg::OUT_DATA_W;

    // One result beat, fields as they come out on m_axis
    typedef struct packed {
        logic                  known;
        logic                  changed;
        logic                  valid;
        logic [TAG_IN_W-1:0]   tag;
        logic [CNT_OUT_W-1:0]  cnt;
        logic [FILL_OUT_W-1:0] fill;
    } t_hist_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: key_index, block_tag, entry_position, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // tuser: opcode, backward_mode
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // tdata: key_known, history_changed, entry_valid, entry_tag, entry_count,
    //        history_fill, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Predicted table state
    logic                    key_known_tbl  [KEY_COUNT];
    logic [POS_W-1:0]        ring_start_tbl [KEY_COUNT];
    logic [FILL_W-1:0]       ring_fill_tbl  [KEY_COUNT];
    logic [TAG_IN_W-1:0]     slot_tag_tbl   [SLOT_N];
    logic [CNT_OUT_W-1:0]    slot_count_tbl [SLOT_N];

    // Expected beats in order, head and tail count every beat ever stored
    t_hist_result            expect_fifo[EXP_DEPTH];
    int                      exp_head = 0;
    int                      exp_tail = 0;
    logic [KEY_IN_W-1:0]     key_pool[8];
    logic [TAG_IN_W-1:0]     tag_pool[4];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatch_count = 0;
    int commands_sent = 0;
    int beats_checked = 0;
    int saturated_hits = 0;
    int idle_cycles = 0;

    per_key_block_history_table_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Flat slot of a position counted from the front of a key's ring
    function automatic int slot_index(input logic [KEY_IN_W-1:0] key, input int pos);
        return int'(key) * HISTORY_DEPTH + (int'(ring_start_tbl[key]) + pos) % HISTORY_DEPTH;
    endfunction

    // Raise a hit count unless it sits at the ceiling
    function automatic logic bump_count(input int s);
        if (slot_count_tbl[s] < MAX_HITS) begin
            slot_count_tbl[s] = slot_count_tbl[s] + 1'b1;
            return 1'b1;
        end
        saturated_hits++;
        return 1'b0;
    endfunction

    function automatic void store_entry(input int s, input logic [TAG_IN_W-1:0] tag);
        slot_tag_tbl[s]   = tag;
        slot_count_tbl[s] = CNT_OUT_W'(1);
    endfunction

    // Apply one command to the predicted table and form its result beat
    task automatic predict_history(input pkbht_pkg::t_op op, input logic bwd,
                                   input logic [KEY_IN_W-1:0] key,
                                   input logic [TAG_IN_W-1:0] tag,
                                   input logic [POS_IN_W-1:0] pos,
                                   output t_hist_result r);
        int   fill;
        int   s;
        logic in_range;
        r = '0;
        in_range = int'(key) < KEY_COUNT;
        if (in_range && op == pkbht_pkg::OP_REGISTER) begin
            key_known_tbl[key] = 1'b1;
        end
        r.known = in_range && key_known_tbl[key];

        if (r.known && op == pkbht_pkg::OP_RECORD) begin
            fill = int'(ring_fill_tbl[key]);
            if (bwd) begin
                // older block: work on the front, never evict
                s = slot_index(key, 0);
                if (fill > 0 && slot_tag_tbl[s] == tag) begin
                    r.changed = bump_count(s);
                end else if (fill < HISTORY_DEPTH) begin
                    ring_start_tbl[key] = POS_W'((int'(ring_start_tbl[key]) + HISTORY_DEPTH - 1)
                                                 % HISTORY_DEPTH);
                    ring_fill_tbl[key] = FILL_W'(fill + 1);
                    store_entry(slot_index(key, 0), tag);
                    r.changed = 1'b1;
                end
            end else begin
                // newer block: work on the back, drop the oldest when full
                if (fill > 0 && slot_tag_tbl[slot_index(key, fill - 1)] == tag) begin
                    r.changed = bump_count(slot_index(key, fill - 1));
                end else begin
                    if (fill >= HISTORY_DEPTH) begin
                        ring_start_tbl[key] = POS_W'((int'(ring_start_tbl[key]) + 1)
                                                     % HISTORY_DEPTH);
                        fill--;
                    end
                    store_entry(slot_index(key, fill), tag);
                    ring_fill_tbl[key] = FILL_W'(fill + 1);
                    r.changed = 1'b1;
                end
            end
        end

        r.fill = r.known ? FILL_OUT_W'(ring_fill_tbl[key]) : '0;

        if (r.known && op == pkbht_pkg::OP_READ && FILL_OUT_W'(pos) < r.fill) begin
            s = slot_index(key, int'(pos));
            r.valid = 1'b1;
            r.tag   = slot_tag_tbl[s];
            r.cnt   = slot_count_tbl[s];
        end
    endtask

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Drive one command beat, wait for it to be taken, log its expectation
    task automatic send_command(input pkbht_pkg::t_op op, input logic bwd,
                                input logic [KEY_IN_W-1:0] key,
                                input logic [TAG_IN_W-1:0] tag,
                                input logic [POS_IN_W-1:0] pos);
        t_hist_result want;
        // random gap, with junk on the bus while tvalid is low
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = IN_DATA_W'({$urandom, $urandom, $urandom});
            s_axis_tuser  = IN_USER_W'($urandom);
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tdata = '0;
        s_axis_tdata[pkbht_pkg::IN_KEY_LSB +: KEY_IN_W] = key;
        s_axis_tdata[pkbht_pkg::IN_TAG_LSB +: TAG_IN_W] = tag;
        s_axis_tdata[pkbht_pkg::IN_POS_LSB +: POS_IN_W] = pos;
        s_axis_tuser  = {bwd, op};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_history(op, bwd, key, tag, pos, want);
        expect_fifo[exp_tail % EXP_DEPTH] = want;
        exp_tail++;
        commands_sent++;
        @(negedge i_clk);
    endtask

    // Receiver stalls, redrawn every cycle
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [TAG_IN_W-1:0] got,
                                   input logic [TAG_IN_W-1:0] want);
        $display("MISMATCH beat %0d: %s got %h want %h", beats_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [TAG_IN_W-1:0] got,
                               input logic [TAG_IN_W-1:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Compare each taken result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_hist_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_tail == exp_head) begin
                report_mismatch("result beat with nothing pending",
                                m_axis_tdata[pkbht_pkg::OUT_TAG_LSB +: TAG_IN_W], '0);
            end else begin
                want = expect_fifo[exp_head % EXP_DEPTH];
                exp_head++;
                check_field("key_known",
                            TAG_IN_W'(m_axis_tdata[pkbht_pkg::OUT_KNOWN_BIT]),
                            TAG_IN_W'(want.known));
                check_field("history_changed",
                            TAG_IN_W'(m_axis_tdata[pkbht_pkg::OUT_CHANGED_BIT]),
                            TAG_IN_W'(want.changed));
                check_field("entry_valid",
                            TAG_IN_W'(m_axis_tdata[pkbht_pkg::OUT_VALID_BIT]),
                            TAG_IN_W'(want.valid));
                check_field("entry_tag",
                            m_axis_tdata[pkbht_pkg::OUT_TAG_LSB +: TAG_IN_W], want.tag);
                check_field("entry_count",
                            TAG_IN_W'(m_axis_tdata[pkbht_pkg::OUT_CNT_LSB +: CNT_OUT_W]),
                            TAG_IN_W'(want.cnt));
                check_field("history_fill",
                            TAG_IN_W'(m_axis_tdata[pkbht_pkg::OUT_FILL_LSB +: FILL_OUT_W]),
                            TAG_IN_W'(want.fill));
            end
            beats_checked++;
        end
    end

    // End the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Register twice, unused opcode, commands on keys never registered
    task automatic test_register_and_unused();
        send_command(pkbht_pkg::OP_READ,     1'b0, 10'd0,    64'h0, 3'd0);
        send_command(pkbht_pkg::OP_RECORD,   1'b1, 10'd1023, {64{1'b1}}, 3'd0);
        send_command(pkbht_pkg::OP_NONE,     1'b1, 10'd5,    {64{1'b1}}, 3'd7);
        send_command(pkbht_pkg::OP_REGISTER, 1'b0, 10'd1023, 64'h0, 3'd0);
        send_command(pkbht_pkg::OP_REGISTER, 1'b1, 10'd1023, {64{1'b1}}, 3'd7);
        send_command(pkbht_pkg::OP_NONE,     1'b0, 10'd1023, 64'h0, 3'd0);
        send_command(pkbht_pkg::OP_READ,     1'b0, 10'd1023, 64'h0, 3'd7);
    endtask

    // Fill a ring from the front, hit the front, then push on a full ring
    task automatic test_backward_history();
        send_command(pkbht_pkg::OP_REGISTER, 1'b0, 10'd0, 64'h0, 3'd0);
        send_command(pkbht_pkg::OP_RECORD, 1'b1, 10'd0, 64'h0, 3'd0);
        send_command(pkbht_pkg::OP_RECORD, 1'b1, 10'd0, {64{1'b1}}, 3'd0);
        send_command(pkbht_pkg::OP_RECORD, 1'b1, 10'd0, 64'h8000_0000_0000_0000, 3'd0);
        for (int i = 0; i < 5; i++) begin
            send_command(pkbht_pkg::OP_RECORD, 1'b1, 10'd0, {$urandom, $urandom}, 3'd0);
        end
        send_command(pkbht_pkg::OP_RECORD, 1'b1, 10'd0,
                     slot_tag_tbl[slot_index(10'd0, 0)], 3'd0);
        send_command(pkbht_pkg::OP_RECORD, 1'b1, 10'd0, 64'h1, 3'd0);
        send_command(pkbht_pkg::OP_READ, 1'b0, 10'd0, 64'h0, 3'd0);
        send_command(pkbht_pkg::OP_READ, 1'b1, 10'd0, 64'h0, 3'd7);
    endtask

    // Push at the back of a full ring and of an empty one, hit the back
    task automatic test_forward_history();
        send_command(pkbht_pkg::OP_RECORD, 1'b0, 10'd0, 64'h1, 3'd0);
        send_command(pkbht_pkg::OP_RECORD, 1'b0, 10'd0, 64'h1, 3'd0);
        send_command(pkbht_pkg::OP_READ, 1'b0, 10'd0, 64'h0, 3'd7);
        send_command(pkbht_pkg::OP_RECORD, 1'b0, 10'd1023, 64'h0, 3'd0);
        send_command(pkbht_pkg::OP_RECORD, 1'b0, 10'd1023, 64'h0, 3'd0);
        send_command(pkbht_pkg::OP_READ, 1'b0, 10'd1023, 64'h0, 3'd1);
    endtask

    // Hammer one tag until its count sticks at the ceiling
    task automatic test_count_saturation();
        logic [KEY_IN_W-1:0] key;
        logic [TAG_IN_W-1:0] tag;
        key = 10'($urandom_range(2, 1022));
        tag = {$urandom, $urandom};
        send_command(pkbht_pkg::OP_REGISTER, 1'b0, key, 64'h0, 3'd0);
        for (int i = 0; i < MAX_HITS + 1; i++) begin
            send_command(pkbht_pkg::OP_RECORD, i[0], key, tag, 3'd0);
        end
        send_command(pkbht_pkg::OP_READ, 1'b0, key, 64'h0, 3'd0);
        send_command(pkbht_pkg::OP_RECORD, 1'b0, key, ~tag, 3'd0);
        send_command(pkbht_pkg::OP_READ, 1'b1, key, 64'h0, 3'd1);
    endtask

    // Random commands, mostly on a small key pool so rings fill and wrap
    task automatic test_random_traffic(input int count);
        int                  r;
        int                  fill;
        pkbht_pkg::t_op      op;
        logic                bwd;
        logic [KEY_IN_W-1:0] key;
        logic [TAG_IN_W-1:0] tag;
        key_pool[0] = 10'd0;
        key_pool[1] = 10'd1023;
        for (int i = 2; i < 8; i++) key_pool[i] = 10'($urandom);
        for (int i = 0; i < 4; i++) tag_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            op = (r < 10) ? pkbht_pkg::OP_REGISTER :
                 (r < 65) ? pkbht_pkg::OP_RECORD :
                 (r < 95) ? pkbht_pkg::OP_READ : pkbht_pkg::OP_NONE;
            bwd = 1'($urandom_range(1));
            key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)] : 10'($urandom);
            fill = int'(ring_fill_tbl[key]);
            r = $urandom_range(99);
            // favor the tag at the end the record will look at
            if (r < 35 && fill > 0) begin
                tag = slot_tag_tbl[slot_index(key, bwd ? 0 : fill - 1)];
            end else if (r < 60) begin
                tag = tag_pool[$urandom_range(3)];
            end else begin
                tag = {$urandom, $urandom};
            end
            send_command(op, bwd, key, tag, 3'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            key_known_tbl[k]  = 1'b0;
            ring_start_tbl[k] = '0;
            ring_fill_tbl[k]  = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        tx_idle_pct = 9;
        rx_idle_pct = 46;
        test_register_and_unused();
        test_backward_history();
        test_forward_history();
        test_random_traffic(130);

        tx_idle_pct = 46;
        rx_idle_pct = 9;
        test_count_saturation();
        test_random_traffic(130);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(130);

        // drain
        s_axis_tvalid = 1'b0;
        while (exp_tail != exp_head) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d commands sent, %0d result beats checked, %0d saturated hits",
                 commands_sent, beats_checked, saturated_hits);
        $display("covered register, unused opcode, front and back records, full rings");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
